// ===== sv/dda_pkg.sv =====
// Shared constants for the DDA line rasterizer.
// No dependencies; dda_if, dda_back, the top level and the testbench refer to this package.
package dda_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 24'hff0000;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

endpackage

// ===== sv/dda_if.sv =====
// Channel interfaces of the DDA line rasterizer: request and pixel streams.
// Depends on dda_pkg for the color width.
interface dda_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source(output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_out_if #(
  parameter int COORD_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  pixel_x;
  logic signed [COORD_BITS-1:0]  pixel_y;
  logic [dda_pkg::COLOR_W-1:0]   color;
  logic                          last;
  logic                          empty_res;

  modport source(output valid, pixel_x, pixel_y, color, last, empty_res, input ready);
  modport sink(input valid, pixel_x, pixel_y, color, last, empty_res, output ready);
endinterface

// ===== sv/dda_front.sv =====
// Front end: accepts requests and classifies them, computing the line deltas,
// their magnitudes and the step count for loads. Depends on dda_if.
module dda_front #(
  parameter int COORD_BITS = 16
) (
  dda_in_if.sink                   in_i,
  input  logic                     push_ready_i,
  output logic                     push_valid_o,
  output logic [3+5*COORD_BITS-1:0] entry_o
);

  typedef struct packed {
    logic                         op;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0]        mag_x;
    logic [COORD_BITS-1:0]        mag_y;
    logic [COORD_BITS-1:0]        steps;
  } entry_t;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        abs_x;
  logic [COORD_BITS:0]        abs_y;
  entry_t                     entry;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    dx    = {in_i.end_x[COORD_BITS-1], in_i.end_x} - {in_i.start_x[COORD_BITS-1], in_i.start_x};
    dy    = {in_i.end_y[COORD_BITS-1], in_i.end_y} - {in_i.start_y[COORD_BITS-1], in_i.start_y};
    abs_x = dx[COORD_BITS] ? -dx : dx;
    abs_y = dy[COORD_BITS] ? -dy : dy;

    entry.op      = in_i.op;
    entry.neg_x   = dx[COORD_BITS];
    entry.neg_y   = dy[COORD_BITS];
    entry.start_x = in_i.start_x;
    entry.start_y = in_i.start_y;
    // The difference of two endpoints never exceeds the coordinate range in magnitude.
    entry.mag_x   = abs_x[COORD_BITS-1:0];
    entry.mag_y   = abs_y[COORD_BITS-1:0];
    entry.steps   = (abs_x > abs_y) ? abs_x[COORD_BITS-1:0] : abs_y[COORD_BITS-1:0];
  end

  assign entry_o = entry;

endmodule

// ===== sv/dda_queue.sv =====
// Short request queue that decouples the front end from the back end.
// No dependencies.
module dda_queue #(
  parameter int WIDTH = 83,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/dda_back.sv =====
// Back end: divides out the per-axis increments for a load, one quotient bit
// per cycle, and steps the position for pixel requests. Depends on dda_pkg, dda_if.
module dda_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        entry_valid_i,
  output logic                        entry_ready_o,
  input  logic [3+5*COORD_BITS-1:0]   entry_i,
  input  logic [dda_pkg::COLOR_W-1:0] color_i,
  dda_out_if.source                   out_o
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int P    = C + F + 2;
  localparam int IW   = F + 2;
  localparam int CW   = $clog2(F + 2);

  typedef struct packed {
    logic                         op;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0]        mag_x;
    logic [COORD_BITS-1:0]        mag_y;
    logic [COORD_BITS-1:0]        steps;
  } entry_t;

  entry_t e;

  // Control state.
  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [C-1:0]  left_q;
  logic          out_valid_q;

  // Divider and line datapath.
  logic [C-1:0]         div_q;
  logic [C-1:0]         rem_x_q, rem_y_q;
  logic [F:0]           nlo_x_q, nlo_y_q;
  logic [F:0]           quo_x_q, quo_y_q;
  logic                 neg_x_q, neg_y_q;
  logic signed [P-1:0]  pos_x_q, pos_y_q;
  logic signed [IW-1:0] inc_x_q, inc_y_q;

  // Result register.
  logic signed [C-1:0]         pix_x_q, pix_y_q;
  logic [dda_pkg::COLOR_W-1:0] color_q;
  logic                        last_q;
  logic                        empty_q;

  logic         out_free;
  logic         pop;
  logic         pop_load;
  logic         pop_step;
  logic         iterate;
  logic         finish;
  logic [C+F:0] num_x, num_y;
  logic [C:0]   t_x, t_y;
  logic         ge_x, ge_y;
  logic [IW-1:0] q_ext_x, q_ext_y;

  function automatic logic [C-1:0] trunc_pos(input logic signed [P-1:0] a);
    logic [P-1:0] m;
    logic [C+1:0] ip;
    m  = a[P-1] ? -a : a;
    ip = m[P-1:F];
    ip = a[P-1] ? (~ip + 1'b1) : ip;
    return ip[C-1:0];
  endfunction

  assign e             = entry_t'(entry_i);
  assign out_free      = !out_valid_q || out_o.ready;
  assign entry_ready_o = !busy_q && ((e.op == dda_pkg::OP_LOAD) || out_free);
  assign pop           = entry_valid_i && entry_ready_o;
  assign pop_load      = pop && (e.op == dda_pkg::OP_LOAD);
  assign pop_step      = pop && (e.op == dda_pkg::OP_STEP);
  assign iterate       = busy_q && (cnt_q != '0);
  assign finish        = busy_q && (cnt_q == '0);

  // Rounded numerator: |delta| * 2^F + steps / 2.
  assign num_x = {1'b0, e.mag_x, {F{1'b0}}} + (C+F+1)'(e.steps >> 1);
  assign num_y = {1'b0, e.mag_y, {F{1'b0}}} + (C+F+1)'(e.steps >> 1);

  assign t_x  = {rem_x_q, nlo_x_q[F]};
  assign t_y  = {rem_y_q, nlo_y_q[F]};
  assign ge_x = t_x >= {1'b0, div_q};
  assign ge_y = t_y >= {1'b0, div_q};

  assign q_ext_x = {1'b0, quo_x_q};
  assign q_ext_y = {1'b0, quo_y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (pop_load) begin
        left_q <= e.steps;
        busy_q <= (e.steps != '0);
        cnt_q  <= CW'(F + 1);
      end else if (iterate) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end else if (pop_step && (left_q != '0)) begin
        left_q <= left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_load) begin
      pos_x_q <= {{2{e.start_x[C-1]}}, e.start_x, {F{1'b0}}};
      pos_y_q <= {{2{e.start_y[C-1]}}, e.start_y, {F{1'b0}}};
      inc_x_q <= '0;
      inc_y_q <= '0;
      div_q   <= e.steps;
      neg_x_q <= e.neg_x;
      neg_y_q <= e.neg_y;
      // The quotient fits F+1 bits, so the top numerator bits start below the divisor.
      rem_x_q <= num_x[C+F:F+1];
      rem_y_q <= num_y[C+F:F+1];
      nlo_x_q <= num_x[F:0];
      nlo_y_q <= num_y[F:0];
      quo_x_q <= '0;
      quo_y_q <= '0;
    end else if (iterate) begin
      rem_x_q <= ge_x ? C'(t_x - {1'b0, div_q}) : t_x[C-1:0];
      rem_y_q <= ge_y ? C'(t_y - {1'b0, div_q}) : t_y[C-1:0];
      nlo_x_q <= {nlo_x_q[F-1:0], 1'b0};
      nlo_y_q <= {nlo_y_q[F-1:0], 1'b0};
      quo_x_q <= {quo_x_q[F-1:0], ge_x};
      quo_y_q <= {quo_y_q[F-1:0], ge_y};
    end else if (finish) begin
      inc_x_q <= neg_x_q ? -q_ext_x : q_ext_x;
      inc_y_q <= neg_y_q ? -q_ext_y : q_ext_y;
    end else if (pop_step && (left_q != '0)) begin
      pos_x_q <= pos_x_q + P'(inc_x_q);
      pos_y_q <= pos_y_q + P'(inc_y_q);
    end

    if (pop_step) begin
      if (left_q == '0) begin
        pix_x_q <= '0;
        pix_y_q <= '0;
        color_q <= '0;
        last_q  <= 1'b0;
        empty_q <= 1'b1;
      end else begin
        pix_x_q <= trunc_pos(pos_x_q);
        pix_y_q <= trunc_pos(pos_y_q);
        color_q <= color_i;
        last_q  <= (left_q == C'(1));
        empty_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_x   = pix_x_q;
  assign out_o.pixel_y   = pix_y_q;
  assign out_o.color     = color_q;
  assign out_o.last      = last_q;
  assign out_o.empty_res = empty_q;

endmodule

// ===== sv/dda_line_rasterizer.sv =====
// Top level of the DDA line rasterizer: color register, front end, queue, back end.
// Depends on dda_pkg, dda_if, dda_front, dda_queue and dda_back.
//
//   Channel   Direction  Handshake           Carries
//   in_i      sink       valid/ready         op, start_x, start_y, end_x, end_y
//   out_o     source     valid/ready         pixel_x, pixel_y, color, last, empty_res
//   color_*   input      color_we_i strobe   24-bit pixel color
//
// A pixel request goes straight to the output register in the back end; a load runs the
// bit-per-cycle divider, which holds off further requests, and a zero-length load skips it.
// A two-entry queue lets requests be taken while the divider runs or the output stalls.
// Reset is asynchronous and active low; it empties the queue, drops any line and
// restores the default color. A full output register holds pixel requests in the queue.
module dda_line_rasterizer #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dda_in_if.sink                      in_i,
  dda_out_if.source                   out_o,
  input  logic                        color_we_i,
  input  logic [dda_pkg::COLOR_W-1:0] color_i
);

  localparam int ENTRY_W = 3 + 5 * COORD_BITS;

  logic [dda_pkg::COLOR_W-1:0] color_q;
  logic                        push_valid;
  logic                        push_ready;
  logic [ENTRY_W-1:0]          push_data;
  logic                        pop_valid;
  logic                        pop_ready;
  logic [ENTRY_W-1:0]          pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= dda_pkg::DEFAULT_COLOR;
    end else if (color_we_i) begin
      color_q <= color_i;
    end
  end

  dda_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .entry_o      (push_data)
  );

  dda_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(2)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dda_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (pop_valid),
    .entry_ready_o (pop_ready),
    .entry_i       (pop_data),
    .color_i       (color_q),
    .out_o         (out_o)
  );

endmodule

// ===== sim/tb_dda_line_rasterizer.sv =====
// Self-checking testbench for the DDA line rasterizer: random and directed line requests,
// predicted pixels compared with the block's output stream.
// Depends on dda_pkg, dda_if and dda_line_rasterizer.
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;

  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam longint UNIT    = longint'(1) << FRAC_BITS;
  localparam int LOAD_CYCLES = FRAC_BITS + 3;
  localparam int SETTLE      = 4 * LOAD_CYCLES;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 460;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
  } req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [dda_pkg::COLOR_W-1:0]  color;
    logic                         last;
    logic                         is_empty;
  } pix_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        color_we_i;
  logic [dda_pkg::COLOR_W-1:0] color_i;

  dda_in_if  #(.COORD_BITS(COORD_BITS)) req_if ();
  dda_out_if #(.COORD_BITS(COORD_BITS)) pix_if ();

  dda_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (req_if),
    .out_o     (pix_if),
    .color_we_i(color_we_i),
    .color_i   (color_i)
  );

  // Line state mirrored from the block.
  longint                      line_pos_x;
  longint                      line_pos_y;
  longint                      line_inc_x;
  longint                      line_inc_y;
  longint                      pixels_left;
  logic [dda_pkg::COLOR_W-1:0] pen_color;

  req_t pending_q[$];
  pix_t pixel_expect_q[$];
  req_t cur_req;
  int   sent_cnt;
  int   pix_cnt;
  int   err_cnt;
  int   hold_left;
  logic hold_done;
  int   quiet_cycles;
  logic calm;

  // No idling on either side while this window of requests passes.
  assign calm = (sent_cnt >= 700) && (sent_cnt < 1000);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint axis_inc(longint d, longint n);
    longint q;
    q = (((d < 0) ? -d : d) * UNIT + n / 2) / n;
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic [COORD_BITS-1:0] pos_to_coord(longint acc);
    longint ip;
    ip = (acc < 0) ? -((-acc) >> FRAC_BITS) : (acc >> FRAC_BITS);
    return ip[COORD_BITS-1:0];
  endfunction

  function automatic void apply_request(input req_t r);
    longint dx, dy, ax, ay, n;
    pix_t   p;
    if (r.op == dda_pkg::OP_LOAD) begin
      dx = longint'($signed(r.ex)) - longint'($signed(r.sx));
      dy = longint'($signed(r.ey)) - longint'($signed(r.sy));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      n  = (ax > ay) ? ax : ay;
      line_pos_x = longint'($signed(r.sx)) * UNIT;
      line_pos_y = longint'($signed(r.sy)) * UNIT;
      line_inc_x = (n == 0) ? 0 : axis_inc(dx, n);
      line_inc_y = (n == 0) ? 0 : axis_inc(dy, n);
      pixels_left = n;
    end else begin
      p = '0;
      if (pixels_left == 0) begin
        p.is_empty = 1'b1;
      end else begin
        p.px    = pos_to_coord(line_pos_x);
        p.py    = pos_to_coord(line_pos_y);
        p.color = pen_color;
        p.last  = (pixels_left == 1);
        line_pos_x  += line_inc_x;
        line_pos_y  += line_inc_y;
        pixels_left -= 1;
      end
      pixel_expect_q.push_back(p);
    end
  endfunction

  task automatic push_load(input int x1, input int y1, input int x2, input int y2);
    req_t r;
    r.op = dda_pkg::OP_LOAD;
    r.sx = x1[COORD_BITS-1:0];
    r.sy = y1[COORD_BITS-1:0];
    r.ex = x2[COORD_BITS-1:0];
    r.ey = y2[COORD_BITS-1:0];
    pending_q.push_back(r);
  endtask

  // Coordinate fields of a pixel request are don't-care, so they carry noise.
  task automatic push_steps(input int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      r    = req_t'({1'b0, $urandom, $urandom});
      r.op = dda_pkg::OP_STEP;
      pending_q.push_back(r);
    end
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic queue_random_line();
    int sx, sy, ex, ey, dx, dy, span, roll, n, cnt;
    roll = $urandom_range(99);
    sx   = rand_coord();
    sy   = rand_coord();
    if (roll < 4) begin
      // Long line anywhere in the plane, only partly drawn before the next load.
      ex  = rand_coord();
      ey  = rand_coord();
      cnt = $urandom_range(16);
    end else begin
      span = (roll < 24) ? 64 : 12;
      dx   = int'($urandom_range(2 * span)) - span;
      dy   = int'($urandom_range(2 * span)) - span;
      case ($urandom_range(9))
        0: dy = 0;
        1: dy = dx;
        2: dy = -dx;
        3: dx = 0;
        default: ;
      endcase
      ex = sx + dx;
      if (ex > 32767 || ex < -32768) ex = sx - dx;
      ey = sy + dy;
      if (ey > 32767 || ey < -32768) ey = sy - dy;
      n  = ((ex > sx) ? ex - sx : sx - ex);
      if (((ey > sy) ? ey - sy : sy - ey) > n) n = (ey > sy) ? ey - sy : sy - ey;
      roll = $urandom_range(9);
      if (roll < 8) cnt = n + 1;
      else if (roll == 8) cnt = n;
      else cnt = $urandom_range(n);
    end
    push_load(sx, sy, ex, ey);
    push_steps(cnt);
  endtask

  task automatic fill_random(input int target);
    while (pending_q.size() < target) begin
      if ($urandom_range(9) != 0) begin
        queue_random_line();
      end else if ($urandom_range(1) == 0) begin
        push_load(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else begin
        push_steps($urandom_range(3, 1));
      end
    end
  endtask

  // Waits until every request is taken and every pixel has come back, then lets the
  // divides of any loads still in the block run out. The check is made between edges.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || req_if.valid || pixel_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_color(input logic [dda_pkg::COLOR_W-1:0] c);
    color_we_i <= 1'b1;
    color_i    <= c;
    pen_color   = c;
    @(posedge clk_i);
    color_we_i <= 1'b0;
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid   <= 1'b0;
      req_if.op      <= dda_pkg::OP_LOAD;
      req_if.start_x <= '0;
      req_if.start_y <= '0;
      req_if.end_x   <= '0;
      req_if.end_y   <= '0;
      sent_cnt       <= 0;
      line_pos_x      = 0;
      line_pos_y      = 0;
      line_inc_x      = 0;
      line_inc_y      = 0;
      pixels_left     = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_request(cur_req);
        sent_cnt <= sent_cnt + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
          cur_req         = pending_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.op      <= cur_req.op;
          req_if.start_x <= cur_req.sx;
          req_if.start_y <= cur_req.sy;
          req_if.end_x   <= cur_req.ex;
          req_if.end_y   <= cur_req.ey;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor and receiver back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.ready <= 1'b0;
      pix_cnt      <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      err_cnt       = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        pix_cnt <= pix_cnt + 1;
        if (pixel_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b empty=%b", $time,
                   pix_if.pixel_x, pix_if.pixel_y, pix_if.color, pix_if.last,
                   pix_if.empty_res);
        end else begin
          check_pixel(pixel_expect_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        pix_if.ready <= 1'b0;
      end else if (!hold_done && pix_cnt >= 400) begin
        // One long stall so the queue fills and the block stops taking requests.
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  function automatic void check_pixel(input pix_t want);
    pix_t got;
    got = '{pix_if.pixel_x, pix_if.pixel_y, pix_if.color, pix_if.last, pix_if.empty_res};
    if (got.px !== want.px || got.py !== want.py || got.color !== want.color ||
        got.last !== want.last || got.is_empty !== want.is_empty) begin
      err_cnt++;
      $write("%0t: expected x=%0d y=%0d color=%h last=%b empty=%b, ",
             $time, want.px, want.py, want.color, want.last, want.is_empty);
      $display("got x=%0d y=%0d color=%h last=%b empty=%b",
               got.px, got.py, got.color, got.last, got.is_empty);
    end
  endfunction

  // Watchdog on cycles in which neither channel moves a request or a pixel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((req_if.valid && req_if.ready) || (pix_if.valid && pix_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    color_we_i   <= 1'b0;
    color_i      <= '0;
    pen_color    = dda_pkg::DEFAULT_COLOR;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, default color: empty steps, zero-length line, full-range
    // lines dropped by a new load, negative positions and lines ending at the edge.
    push_steps(1);
    push_load(5, 5, 5, 5);
    push_steps(1);
    push_load(-32768, -32768, 32767, 32767);
    push_steps(2);
    push_load(32767, -32768, -32768, 32767);
    push_steps(1);
    push_load(0, 0, 3, -2);
    push_steps(4);
    push_load(-1, -1, -4, 1);
    push_steps(4);
    push_load(32767, 32767, 32760, 32767);
    push_steps(3);
    wait_idle();

    write_color('0);
    fill_random(PHASE_ITEMS);
    wait_idle();
    write_color('1);
    fill_random(PHASE_ITEMS);
    wait_idle();
    for (int ph = 0; ph < 2; ph++) begin
      write_color(dda_pkg::COLOR_W'($urandom_range(24'hffffff)));
      fill_random(PHASE_ITEMS);
      wait_idle();
    end

    if (err_cnt == 0 && pixel_expect_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
